// File: src/gdd_pkg.sv
// Shared types, constants and calendar functions for the date difference core.
`default_nettype none

package gdd_pkg;

  localparam int unsigned YEAR_W      = 14;
  localparam int unsigned MONTH_W     = 4;
  localparam int unsigned DAY_W       = 5;
  localparam int unsigned COUNT_W     = 22;
  localparam int unsigned MAX_YEAR_DEF = 9999;

  // Shifted year: year + 400, minus one for January and February.
  localparam int unsigned EPOCH_SHIFT = 400;
  localparam int unsigned YS_W        = 15;
  localparam int unsigned CENTURY     = 100;
  localparam int unsigned REM_W       = $clog2(CENTURY);

  // ys / 100 as (ys * 5243) >> 19, exact for ys below 43699
  localparam int unsigned        RECIP_W     = 13;
  localparam int unsigned        RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100   = 13'd5243;

  // Signed running difference of two day numbers.
  localparam int unsigned ACC_W       = 24;
  localparam int unsigned OFFSET_W    = 9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
  localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
  localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
  localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
  localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_CHK,
    ST_SUM,
    ST_ABS,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_ADD,
    ACC_SUB,
    ACC_NEG
  } acc_op_e;

  // Terms of one day number, fed one per cycle through the adder.
  typedef enum logic [3:0] {
    T_Y256,
    T_Y64,
    T_Y32,
    T_Y8,
    T_Y4,
    T_Y1,
    T_YQUAD,
    T_CENT,
    T_QUADCENT,
    T_MONTH,
    T_DAY
  } term_e;

  typedef struct packed {
    acc_op_e          op;
    logic [ACC_W-1:0] operand;
  } acc_cmd_t;

  typedef struct packed {
    logic            start;
    logic [YS_W-1:0] dividend;
  } div_cmd_t;

  typedef struct packed {
    logic             done;
    logic [YS_W-1:0]  quotient;
    logic [REM_W-1:0] remainder;
  } div_res_t;

  function automatic logic [DAY_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
    logic [DAY_W-1:0] len;
    unique case (m)
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: len = 5'd31;
      MON_APR, MON_JUN, MON_SEP, MON_NOV:                           len = 5'd30;
      MON_FEB: len = leap ? 5'd29 : 5'd28;
      default: len = '0;
    endcase
    return len;
  endfunction

  // Days from March 1 to the first of the month, year starting in March.
  function automatic logic [OFFSET_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
    logic [OFFSET_W-1:0] off;
    unique case (m)
      MON_MAR: off = 9'd0;
      MON_APR: off = 9'd31;
      MON_MAY: off = 9'd61;
      MON_JUN: off = 9'd92;
      MON_JUL: off = 9'd122;
      MON_AUG: off = 9'd153;
      MON_SEP: off = 9'd184;
      MON_OCT: off = 9'd214;
      MON_NOV: off = 9'd245;
      MON_DEC: off = 9'd275;
      MON_JAN: off = 9'd306;
      MON_FEB: off = 9'd337;
      default: off = '0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// File: src/gdd_if.sv
// Request and result channel interfaces of the date difference core.
`default_nettype none

interface gdd_req_if;
  import gdd_pkg::*;

  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  first_year;
  logic [MONTH_W-1:0] first_month;
  logic [DAY_W-1:0]   first_day;
  logic [YEAR_W-1:0]  second_year;
  logic [MONTH_W-1:0] second_month;
  logic [DAY_W-1:0]   second_day;

  modport source (
    output valid, first_year, first_month, first_day,
           second_year, second_month, second_day,
    input  ready
  );

  modport sink (
    input  valid, first_year, first_month, first_day,
           second_year, second_month, second_day,
    output ready
  );
endinterface

interface gdd_res_if;
  import gdd_pkg::*;

  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] day_count;
  logic               date_invalid;

  modport source (
    output valid, day_count, date_invalid,
    input  ready
  );

  modport sink (
    input  valid, day_count, date_invalid,
    output ready
  );
endinterface

`default_nettype wire

// File: src/gdd_div100.sv
// Divide of the shifted year by one hundred: reciprocal multiply, then the remainder.
`default_nettype none

module gdd_div100 (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gdd_pkg::div_cmd_t cmd_i,
  output gdd_pkg::div_res_t res_o
);
  import gdd_pkg::*;

  localparam int unsigned PROD_W = YS_W + RECIP_W;

  logic             quo_step_q, quo_step_d;
  logic             rem_step_q, rem_step_d;
  logic             done_q, done_d;
  logic [YS_W-1:0]  dvd_q, dvd_d;
  logic [YS_W-1:0]  quo_q, quo_d;
  logic [REM_W-1:0] rem_q, rem_d;

  logic [PROD_W-1:0] prod;
  logic [YS_W-1:0]   quo_x100;
  logic [REM_W-1:0]  rem_calc;

  assign prod     = PROD_W'(dvd_q) * PROD_W'(RECIP_100);
  // 100 * q as 64q + 32q + 4q; q stays below 2^9 for a 15-bit dividend
  assign quo_x100 = {quo_q[YS_W-7:0], 6'd0} + {quo_q[YS_W-6:0], 5'd0}
                  + {quo_q[YS_W-3:0], 2'd0};
  assign rem_calc = REM_W'(dvd_q - quo_x100);

  always_comb begin
    quo_step_d = 1'b0;
    rem_step_d = quo_step_q;
    done_d     = rem_step_q;
    dvd_d      = dvd_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    if (cmd_i.start) begin
      quo_step_d = 1'b1;
      dvd_d      = cmd_i.dividend;
    end
    if (quo_step_q) quo_d = YS_W'(prod >> RECIP_SHIFT);
    if (rem_step_q) rem_d = rem_calc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_step_q <= 1'b0;
      rem_step_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      quo_step_q <= quo_step_d;
      rem_step_q <= rem_step_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = quo_q;
  assign res_o.remainder = rem_q;

endmodule

`default_nettype wire

// File: src/gdd_accum.sv
// Shared add/subtract accumulator that builds the signed day difference.
`default_nettype none

module gdd_accum (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gdd_pkg::acc_cmd_t         cmd_i,
  output logic [gdd_pkg::ACC_W-1:0] acc_o
);
  import gdd_pkg::*;

  logic [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0] op_a, op_b, sum;
  logic             sub;

  assign sub  = (cmd_i.op == ACC_SUB) || (cmd_i.op == ACC_NEG);
  assign op_a = (cmd_i.op == ACC_NEG) ? '0 : acc_q;
  assign op_b = (cmd_i.op == ACC_NEG) ? acc_q : cmd_i.operand;
  assign sum  = op_a + (sub ? ~op_b : op_b) + ACC_W'(sub);

  always_comb begin
    unique case (cmd_i.op)
      ACC_CLR:                   acc_d = '0;
      ACC_ADD, ACC_SUB, ACC_NEG: acc_d = sum;
      default:                   acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// File: src/gregorian_date_difference_core.sv
// Top level: days between two Gregorian dates, one shared adder under a sequencer.
//
//   channel  dir  handshake      payload
//   req_i    in   valid/ready    first_/second_ year, month, day
//   res_o    out  valid/ready    day_count, date_invalid
//
// Per date an item runs a start step, a divide by one hundred (quotient,
// remainder, done), a check, and 11 accumulate steps through the single
// adder; then one step takes the magnitude and one loads the output register.
// A bad date skips the accumulate steps and goes straight to loading the result.
// req_i.ready is high only while the sequencer is idle; a finished result
// waits in the output register, and the next request is taken meanwhile.
// Reset clears the sequencer, the divider, the accumulator and the output valid.
`default_nettype none

module gregorian_date_difference_core #(
  parameter int unsigned MAX_YEAR = gdd_pkg::MAX_YEAR_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  gdd_req_if.sink   req_i,
  gdd_res_if.source res_o
);
  import gdd_pkg::*;

  state_e state_q, state_d;
  logic   sel_q, sel_d;
  term_e  term_q, term_d;
  logic   invalid_q, invalid_d;
  logic   res_valid_q, res_valid_d;

  logic [YEAR_W-1:0]  y1_q, y2_q;
  logic [MONTH_W-1:0] m1_q, m2_q;
  logic [DAY_W-1:0]   d1_q, d2_q;
  logic [COUNT_W-1:0] count_q;
  logic               res_inv_q;

  logic accept, res_load;

  logic [YEAR_W-1:0]  y_cur;
  logic [MONTH_W-1:0] m_cur;
  logic [DAY_W-1:0]   d_cur;
  logic [YS_W-1:0]    ys_cur;
  logic               leap;
  logic [DAY_W-1:0]   dim;
  logic               date_ok;

  acc_cmd_t         acc_cmd;
  logic [ACC_W-1:0] acc;
  div_cmd_t         div_cmd;
  div_res_t         div_res;

  logic [ACC_W-1:0]   term_val;
  logic               term_neg;
  logic [COUNT_W-1:0] count_sat;

  assign accept   = req_i.valid && req_i.ready;
  assign res_load = (state_q == ST_DONE) && (!res_valid_q || res_o.ready);

  // current date
  assign y_cur  = sel_q ? y2_q : y1_q;
  assign m_cur  = sel_q ? m2_q : m1_q;
  assign d_cur  = sel_q ? d2_q : d1_q;
  assign ys_cur = YS_W'(y_cur) + YS_W'(EPOCH_SHIFT) - YS_W'(m_cur <= MON_FEB);

  // For February the shifted year is year + 399: a century year leaves a
  // remainder of 99, and a multiple of 400 then has a quotient of 3 mod 4.
  assign leap = (y_cur[1:0] == 2'b00) &&
                ((div_res.remainder != REM_W'(CENTURY - 1)) ||
                 (div_res.quotient[1:0] == 2'b11));
  assign dim  = days_in_month(m_cur, leap);
  assign date_ok = (32'(y_cur) <= MAX_YEAR) && (m_cur >= MON_JAN) &&
                   (m_cur <= MON_DEC) && (d_cur != '0) && (d_cur <= dim);

  gdd_div100 u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .res_o  (div_res)
  );

  gdd_accum u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (acc_cmd),
    .acc_o  (acc)
  );

  // 365 * ys as shifted copies, then the leap corrections and the offsets
  always_comb begin
    unique case (term_q)
      T_Y256:     term_val = ACC_W'({ys_cur, 8'd0});
      T_Y64:      term_val = ACC_W'({ys_cur, 6'd0});
      T_Y32:      term_val = ACC_W'({ys_cur, 5'd0});
      T_Y8:       term_val = ACC_W'({ys_cur, 3'd0});
      T_Y4:       term_val = ACC_W'({ys_cur, 2'd0});
      T_Y1:       term_val = ACC_W'(ys_cur);
      T_YQUAD:    term_val = ACC_W'(ys_cur >> 2);
      T_CENT:     term_val = ACC_W'(div_res.quotient);
      T_QUADCENT: term_val = ACC_W'(div_res.quotient >> 2);
      T_MONTH:    term_val = ACC_W'(month_offset(m_cur));
      T_DAY:      term_val = ACC_W'(d_cur - DAY_W'(1));
      default:    term_val = '0;
    endcase
  end

  assign term_neg  = (term_q == T_CENT);
  assign count_sat = (acc > ACC_W'(COUNT_MAX)) ? COUNT_MAX : acc[COUNT_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (div_res.done) state_d = ST_CHK;
      ST_CHK:   state_d = date_ok ? ST_SUM : ST_DONE;
      ST_SUM: begin
        if (term_q == T_DAY) state_d = sel_q ? ST_ABS : ST_START;
      end
      ST_ABS:   state_d = ST_DONE;
      ST_DONE:  if (res_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    acc_cmd.op       = ACC_HOLD;
    acc_cmd.operand  = term_val;
    div_cmd.start    = 1'b0;
    div_cmd.dividend = ys_cur;
    sel_d            = sel_q;
    term_d           = term_q;
    invalid_d        = invalid_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          acc_cmd.op = ACC_CLR;
          sel_d      = 1'b0;
          invalid_d  = 1'b0;
        end
      end
      ST_START: div_cmd.start = 1'b1;
      ST_CHK: begin
        term_d = T_Y256;
        if (!date_ok) invalid_d = 1'b1;
      end
      ST_SUM: begin
        // second date and the century term go in negated
        acc_cmd.op = (sel_q ^ term_neg) ? ACC_SUB : ACC_ADD;
        if (term_q == T_DAY) begin
          sel_d = 1'b1;
        end else begin
          term_d = term_e'(term_q + 4'd1);
        end
      end
      ST_ABS: if (acc[ACC_W-1]) acc_cmd.op = ACC_NEG;
      default: ;
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_o.ready) res_valid_d = 1'b0;
    if (res_load)    res_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= 1'b0;
      term_q      <= T_Y256;
      invalid_q   <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      term_q      <= term_d;
      invalid_q   <= invalid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      y1_q <= req_i.first_year;
      m1_q <= req_i.first_month;
      d1_q <= req_i.first_day;
      y2_q <= req_i.second_year;
      m2_q <= req_i.second_month;
      d2_q <= req_i.second_day;
    end
    if (res_load) begin
      count_q   <= invalid_q ? '0 : count_sat;
      res_inv_q <= invalid_q;
    end
  end

  assign req_i.ready        = (state_q == ST_IDLE);
  assign res_o.valid        = res_valid_q;
  assign res_o.day_count    = count_q;
  assign res_o.date_invalid = res_inv_q;

`ifndef SYNTHESIS
  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_START) && !invalid_q && !sel_q)
    else $error("request did not start a new item");

  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide step");

  a_done_magnitude : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && !invalid_q |-> !acc[ACC_W-1])
    else $error("difference still negative at result");

  a_invalid_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.date_invalid |-> (res_o.day_count == '0))
    else $error("invalid result carries a nonzero count");
`endif

endmodule

`default_nettype wire
